@@ hdl/assert_macros.svh @@
// assertion macros used by the rtl file of the gather hash core
// no dependencies; each macro expands to one named concurrent assertion
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked on every rising edge of clock, switched off while reset is high
`define ASSERT_CLK(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// checked on every rising edge of clock, reset included
`define ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) (prop)) else $error(msg);

`endif

@@ hdl/sfgh_pkg.sv @@
// shared types, constants and the fnv multiply for the strided gather hash core
// no dependencies
package sfgh_pkg;

   localparam int unsigned HASH_W    = 64;
   localparam int unsigned COUNT_W   = 16;
   localparam int unsigned STRIDE_W  = 12;
   localparam int unsigned VIDX_W    = 17;
   localparam int unsigned BYTES_W   = 32;
   localparam int unsigned CSR_ADDR_W = 6;

   localparam logic [HASH_W-1:0]   FNV_BASIS = 64'hcbf2_9ce4_8422_2325;
   localparam logic [STRIDE_W:0]   POS_BYTES = 13'd12;
   localparam logic [STRIDE_W-1:0] STRIDE_RESET = 12'd12;
   localparam logic [VIDX_W-1:0]   VIDX_MAX = 17'h1_ffff;
   localparam logic [BYTES_W-1:0]  BYTES_MAX = 32'hffff_ffff;

   typedef enum logic [2:0] {
      REG_HASH_SEED       = 3'd0,
      REG_GATHER_MODE     = 3'd1,
      REG_VERTEX_COUNT    = 3'd2,
      REG_VERTEX_STRIDE   = 3'd3,
      REG_POSITION_OFFSET = 3'd4
   } csr_index_type;

   // x * 0x100000001b3 mod 2^64: the prime has bits 40, 8, 7, 5, 4, 1 and 0 set
   function automatic logic [HASH_W-1:0] fnv_mul(input logic [HASH_W-1:0] x);
      fnv_mul = x + (x << 40) + (x << 8) + (x << 7) + (x << 5) + (x << 4) + (x << 1);
   endfunction

endpackage

@@ hdl/strided_fnv1a_gather_hash_core.sv @@
// strided fnv-1a 64 gather hash core: csr block, stream state and result registers
// depends on sfgh_pkg and assert_macros.svh
//
// throughput: one byte per cycle; req_tready drops only while two results wait unread
// a result is on rsp in the cycle after the transfer of its last byte when the
// result register is free, else it waits in the second result register behind it
// the hash update is a single shift-add of seven terms between state registers
// reset (synchronous, active high) loads the register reset values and empties rsp
`include "assert_macros.svh"

module strided_fnv1a_gather_hash_core (
   input  logic        clock,
   input  logic        reset,
   // input stream
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] data_byte
   input  logic        req_tlast,   // last_byte
   // result stream
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [63:0] rsp_tdata,   // [63:0] hash_value
   output logic        rsp_tuser,   // layout_error
   // configuration
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [sfgh_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [63:0] csr_pwdata,
   output logic [63:0] csr_prdata,
   output logic        csr_pready
);

   // configuration registers
   logic [sfgh_pkg::HASH_W-1:0]   hash_seed_ff;
   logic                          gather_mode_ff;
   logic [sfgh_pkg::COUNT_W-1:0]  vertex_count_ff;
   logic [sfgh_pkg::STRIDE_W-1:0] vertex_stride_ff;
   logic [sfgh_pkg::STRIDE_W-1:0] position_offset_ff;

   // stream state
   logic [sfgh_pkg::HASH_W-1:0]   running_hash_ff, running_hash_in;
   logic [sfgh_pkg::BYTES_W-1:0]  bytes_seen_ff, bytes_seen_in;
   logic [sfgh_pkg::STRIDE_W-1:0] offset_ff, offset_in;
   logic [sfgh_pkg::VIDX_W-1:0]   vidx_ff, vidx_in;

   // result register
   logic                          rsp_valid_ff, rsp_valid_in;
   logic [sfgh_pkg::HASH_W-1:0]   rsp_hash_ff, rsp_hash_in;
   logic                          rsp_error_ff, rsp_error_in;

   // second result register, fills only while the first one waits
   logic                          skid_valid_ff, skid_valid_in;
   logic [sfgh_pkg::HASH_W-1:0]   skid_hash_ff, skid_hash_in;
   logic                          skid_error_ff, skid_error_in;

   logic                          req_fire;
   logic                          csr_write;
   sfgh_pkg::csr_index_type       csr_index;
   logic                          take;
   logic [sfgh_pkg::HASH_W-1:0]   hash_base;
   logic [sfgh_pkg::HASH_W-1:0]   hash_next;
   logic                          stride_wrap;
   logic [sfgh_pkg::COUNT_W-1:0]  count_minus_one;
   logic [27:0]                   span_product;
   logic [28:0]                   last_end;
   logic                          layout_ok;
   logic                          result_fire;
   logic                          result_error;
   logic [sfgh_pkg::HASH_W-1:0]   result_hash;

   // ---------------------------------------------------------------- csr port
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign csr_index  = sfgh_pkg::csr_index_type'(csr_paddr[5:3]);

   always_ff @(posedge clock) begin
      if (reset) begin
         hash_seed_ff       <= sfgh_pkg::FNV_BASIS;
         gather_mode_ff     <= 1'b0;
         vertex_count_ff    <= '0;
         vertex_stride_ff   <= sfgh_pkg::STRIDE_RESET;
         position_offset_ff <= '0;
      end else if (csr_write) begin
         unique case (csr_index)
            sfgh_pkg::REG_HASH_SEED:       hash_seed_ff       <= csr_pwdata;
            sfgh_pkg::REG_GATHER_MODE:     gather_mode_ff     <= csr_pwdata[0];
            sfgh_pkg::REG_VERTEX_COUNT:    vertex_count_ff    <= csr_pwdata[15:0];
            sfgh_pkg::REG_VERTEX_STRIDE:   vertex_stride_ff   <= csr_pwdata[11:0];
            sfgh_pkg::REG_POSITION_OFFSET: position_offset_ff <= csr_pwdata[11:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_index)
         sfgh_pkg::REG_HASH_SEED:       csr_prdata = hash_seed_ff;
         sfgh_pkg::REG_GATHER_MODE:     csr_prdata = {63'd0, gather_mode_ff};
         sfgh_pkg::REG_VERTEX_COUNT:    csr_prdata = {48'd0, vertex_count_ff};
         sfgh_pkg::REG_VERTEX_STRIDE:   csr_prdata = {52'd0, vertex_stride_ff};
         sfgh_pkg::REG_POSITION_OFFSET: csr_prdata = {52'd0, position_offset_ff};
         default:                       csr_prdata = '0;
      endcase
   end

   // ---------------------------------------------------------------- hash path
   assign req_tready = ~skid_valid_ff;
   assign req_fire   = req_tvalid & req_tready;

   // first byte of a buffer starts from the seed as it stands now
   assign hash_base = (bytes_seen_ff == '0) ? hash_seed_ff : running_hash_ff;

   assign take = ~gather_mode_ff
               | ((vidx_ff < {1'b0, vertex_count_ff})
                  & (offset_ff >= position_offset_ff)
                  & ({1'b0, offset_ff} < ({1'b0, position_offset_ff} + sfgh_pkg::POS_BYTES)));

   assign hash_next = take ? sfgh_pkg::fnv_mul(hash_base ^ {56'd0, req_tdata}) : hash_base;

   // a stride of zero or one wraps on every byte
   assign stride_wrap = ({1'b0, offset_ff} + 13'd1) >= {1'b0, vertex_stride_ff};

   // layout check, against the length including this byte
   assign count_minus_one = vertex_count_ff - 16'd1;
   assign span_product    = count_minus_one * vertex_stride_ff;
   assign last_end        = {1'b0, span_product} + {17'd0, position_offset_ff}
                          + {16'd0, sfgh_pkg::POS_BYTES};
   assign layout_ok = (vertex_count_ff != '0)
                    & ({1'b0, vertex_stride_ff} >= sfgh_pkg::POS_BYTES)
                    & (({1'b0, position_offset_ff} + sfgh_pkg::POS_BYTES)
                       <= {1'b0, vertex_stride_ff})
                    & ({3'd0, last_end} <= bytes_seen_in);

   always_comb begin
      running_hash_in = running_hash_ff;
      bytes_seen_in   = bytes_seen_ff;
      offset_in       = offset_ff;
      vidx_in         = vidx_ff;
      if (req_fire) begin
         running_hash_in = hash_next;
         if (bytes_seen_ff != sfgh_pkg::BYTES_MAX) begin
            bytes_seen_in = bytes_seen_ff + 32'd1;
         end
         if (gather_mode_ff) begin
            if (stride_wrap) begin
               offset_in = '0;
               if (vidx_ff != sfgh_pkg::VIDX_MAX) begin
                  vidx_in = vidx_ff + 17'd1;
               end
            end else begin
               offset_in = offset_ff + 12'd1;
            end
         end
      end
   end

   assign result_fire  = req_fire & req_tlast;
   assign result_error = gather_mode_ff & ~layout_ok;
   assign result_hash  = result_error ? '0 : hash_next;

   // the second register only ever holds a result while the first one is full
   always_comb begin
      rsp_valid_in  = rsp_valid_ff & ~rsp_tready;
      rsp_hash_in   = rsp_hash_ff;
      rsp_error_in  = rsp_error_ff;
      skid_valid_in = skid_valid_ff;
      skid_hash_in  = skid_hash_ff;
      skid_error_in = skid_error_ff;
      if (skid_valid_ff) begin
         if (rsp_tready) begin
            rsp_valid_in  = 1'b1;
            rsp_hash_in   = skid_hash_ff;
            rsp_error_in  = skid_error_ff;
            skid_valid_in = 1'b0;
         end
      end else if (result_fire) begin
         if (~rsp_valid_ff | rsp_tready) begin
            rsp_valid_in = 1'b1;
            rsp_hash_in  = result_hash;
            rsp_error_in = result_error;
         end else begin
            skid_valid_in = 1'b1;
            skid_hash_in  = result_hash;
            skid_error_in = result_error;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bytes_seen_ff <= '0;
         offset_ff     <= '0;
         vidx_ff       <= '0;
         rsp_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff  <= rsp_valid_in;
         skid_valid_ff <= skid_valid_in;
         if (req_fire & req_tlast) begin
            bytes_seen_ff <= '0;
            offset_ff     <= '0;
            vidx_ff       <= '0;
         end else begin
            bytes_seen_ff <= bytes_seen_in;
            offset_ff     <= offset_in;
            vidx_ff       <= vidx_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      running_hash_ff <= running_hash_in;
      rsp_hash_ff     <= rsp_hash_in;
      rsp_error_ff    <= rsp_error_in;
      skid_hash_ff    <= skid_hash_in;
      skid_error_ff   <= skid_error_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_hash_ff;
   assign rsp_tuser  = rsp_error_ff;

   // ---------------------------------------------------------------- checks
   `ASSERT_CLK(a_rsp_from_last, $rose(rsp_valid_ff) |-> $past(req_fire & req_tlast), "result without a last byte transfer")
   `ASSERT_CLK(a_error_zero_hash, (rsp_valid_ff & rsp_error_ff) |-> (rsp_hash_ff == '0), "layout error with a non-zero hash")
   `ASSERT_CLK(a_restart_after_last, (req_fire & req_tlast) |=> ((bytes_seen_ff == '0) & (vidx_ff == '0) & (offset_ff == '0)), "stream state not restarted after last byte")
   `ASSERT_CLK(a_vidx_step, (vidx_ff != $past(vidx_ff)) |-> ((vidx_ff == '0) || (vidx_ff == $past(vidx_ff) + 17'd1)), "vertex index jumped")
   `ASSERT_CLK(a_skid_behind_rsp, skid_valid_ff |-> rsp_valid_ff, "second result ahead of the first")

endmodule

@@ test/sfgh_hash_checker.sv @@
// scoreboard for the strided fnv-1a gather hash core: tracks csr writes, predicts each
// result from the accepted bytes and compares it with the result stream; needs sfgh_pkg
`timescale 1ns / 1ps

module sfgh_hash_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] data_byte
   input  logic        req_tlast,   // last_byte
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [63:0] rsp_tdata,   // [63:0] hash_value
   input  logic        rsp_tuser,   // layout_error
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [sfgh_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [63:0] csr_pwdata,
   input  logic        csr_pready,
   output int unsigned mismatches,
   output int unsigned pending,
   output int unsigned results_seen,
   output int unsigned layout_errors_seen
);

   localparam logic [63:0] FNV64_PRIME      = 64'h0000_0100_0000_01b3;
   localparam logic [63:0] FNV64_BASIS      = 64'hcbf2_9ce4_8422_2325;
   localparam logic [16:0] VERTEX_INDEX_TOP = 17'h1_ffff;
   localparam int unsigned POSITION_BYTES   = 12;

   typedef struct packed {
      logic [63:0] hash_value;
      logic        layout_error;
   } hash_result_type;

   hash_result_type hash_results_due[$];

   // register copy
   logic [63:0] seed_r;
   logic        strided_r;
   logic [15:0] count_r;
   logic [11:0] stride_r;
   logic [11:0] offset_r;

   // stream state
   logic [63:0] run_hash;
   logic [31:0] bytes_seen;
   logic [11:0] vtx_offset;
   logic [16:0] vtx_index;

   initial begin
      mismatches = 0;
      pending = 0;
      results_seen = 0;
      layout_errors_seen = 0;
   end

   function automatic logic layout_valid(input logic [31:0] length);
      logic [63:0] span;
      logic [63:0] count_w;
      logic [63:0] stride_w;
      logic [63:0] offset_w;
      count_w  = {48'd0, count_r};
      stride_w = {52'd0, stride_r};
      offset_w = {52'd0, offset_r};
      if (count_r == 16'd0)
         return 1'b0;
      if (stride_w < POSITION_BYTES)
         return 1'b0;
      if (offset_w > stride_w - POSITION_BYTES)
         return 1'b0;
      span = (count_w - 64'd1) * stride_w + offset_w + POSITION_BYTES;
      return span <= {32'd0, length};
   endfunction

   task automatic restart_stream();
      run_hash   = seed_r;
      bytes_seen = '0;
      vtx_offset = '0;
      vtx_index  = '0;
   endtask

   task automatic fold_byte(input logic [7:0] data, input logic last);
      logic            use_byte;
      hash_result_type due;
      if (bytes_seen == '0)
         run_hash = seed_r;
      use_byte = 1'b1;
      if (strided_r) begin
         use_byte = (vtx_index < count_r) && (vtx_offset >= offset_r)
                    && (vtx_offset < offset_r + POSITION_BYTES);
         // wrap when the next position would reach the stride
         if (vtx_offset + 1 >= stride_r) begin
            vtx_offset = '0;
            if (vtx_index != VERTEX_INDEX_TOP)
               vtx_index = vtx_index + 1'b1;
         end else begin
            vtx_offset = vtx_offset + 1'b1;
         end
      end
      if (use_byte)
         run_hash = (run_hash ^ {56'd0, data}) * FNV64_PRIME;
      if (bytes_seen != '1)
         bytes_seen = bytes_seen + 1'b1;
      if (last) begin
         if (strided_r && !layout_valid(bytes_seen)) begin
            due.hash_value   = '0;
            due.layout_error = 1'b1;
         end else begin
            due.hash_value   = run_hash;
            due.layout_error = 1'b0;
         end
         hash_results_due.insert(hash_results_due.size(), due);
         restart_stream();
      end
   endtask

   task automatic compare_result();
      hash_result_type due;
      results_seen++;
      if (rsp_tuser === 1'b1)
         layout_errors_seen++;
      if (hash_results_due.size() == 0) begin
         $display("%0t ns: result with nothing due: hash %h error %b",
                  $time, rsp_tdata, rsp_tuser);
         mismatches++;
      end else begin
         due = hash_results_due.pop_front();
         if (rsp_tdata !== due.hash_value) begin
            $display("%0t ns: hash_value expected %h actual %h",
                     $time, due.hash_value, rsp_tdata);
            mismatches++;
         end
         if (rsp_tuser !== due.layout_error) begin
            $display("%0t ns: layout_error expected %b actual %b",
                     $time, due.layout_error, rsp_tuser);
            mismatches++;
         end
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         seed_r    = FNV64_BASIS;
         strided_r = 1'b0;
         count_r   = '0;
         stride_r  = 12'd12;
         offset_r  = '0;
         restart_stream();
         hash_results_due.delete();
      end else begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            case (sfgh_pkg::csr_index_type'(csr_paddr[5:3]))
               sfgh_pkg::REG_HASH_SEED:       seed_r    = csr_pwdata;
               sfgh_pkg::REG_GATHER_MODE:     strided_r = csr_pwdata[0];
               sfgh_pkg::REG_VERTEX_COUNT:    count_r   = csr_pwdata[15:0];
               sfgh_pkg::REG_VERTEX_STRIDE:   stride_r  = csr_pwdata[11:0];
               sfgh_pkg::REG_POSITION_OFFSET: offset_r  = csr_pwdata[11:0];
               default: ;
            endcase
         end
         if (req_tvalid && req_tready)
            fold_byte(req_tdata, req_tlast);
         if (rsp_tvalid && rsp_tready)
            compare_result();
      end
      pending = hash_results_due.size();
   end

endmodule

@@ test/strided_fnv1a_gather_hash_core_tb.sv @@
// testbench top for the strided fnv-1a gather hash core: clock, reset, csr writes,
// byte stream and result sink; checking is done by sfgh_hash_checker, types from sfgh_pkg
`timescale 1ns / 1ps

module strided_fnv1a_gather_hash_core_tb;

   localparam int unsigned ITEM_TARGET = 1950;
   localparam int unsigned HOLD_CYCLES = 300;
   localparam int unsigned CYCLE_LIMIT = 500000;
   localparam logic [63:0] BASIS_SEED  = 64'hcbf2_9ce4_8422_2325;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [7:0]  req_tdata;   // [7:0] data_byte
   logic        req_tlast;   // last_byte
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [63:0] rsp_tdata;   // [63:0] hash_value
   logic        rsp_tuser;   // layout_error
   logic        csr_psel;
   logic        csr_penable;
   logic        csr_pwrite;
   logic [sfgh_pkg::CSR_ADDR_W-1:0] csr_paddr;
   logic [63:0] csr_pwdata;
   logic [63:0] csr_prdata;
   logic        csr_pready;

   int unsigned mismatches;
   int unsigned pending;
   int unsigned results_seen;
   int unsigned layout_errors_seen;

   logic        req_taken;
   logic        hold_req;
   logic        strided_on;
   int unsigned burst_left;
   int unsigned gap_max;
   int unsigned bytes_sent;
   int unsigned buffers_sent;
   int unsigned strided_buffers;
   int unsigned csr_writes;

   strided_fnv1a_gather_hash_core u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tlast   (req_tlast),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   sfgh_hash_checker u_checker (
      .clock              (clock),
      .reset              (reset),
      .req_tvalid         (req_tvalid),
      .req_tready         (req_tready),
      .req_tdata          (req_tdata),
      .req_tlast          (req_tlast),
      .rsp_tvalid         (rsp_tvalid),
      .rsp_tready         (rsp_tready),
      .rsp_tdata          (rsp_tdata),
      .rsp_tuser          (rsp_tuser),
      .csr_psel           (csr_psel),
      .csr_penable        (csr_penable),
      .csr_pwrite         (csr_pwrite),
      .csr_paddr          (csr_paddr),
      .csr_pwdata         (csr_pwdata),
      .csr_pready         (csr_pready),
      .mismatches         (mismatches),
      .pending            (pending),
      .results_seen       (results_seen),
      .layout_errors_seen (layout_errors_seen)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   initial begin
      repeat (CYCLE_LIMIT) @(posedge clock);
      $display("timeout after %0d cycles, %0d results still due", CYCLE_LIMIT, pending);
      $display("Regression FAIL");
      $finish;
   end

   // transfer seen at the last rising edge, read back at the falling edge
   always @(posedge clock)
      req_taken <= req_tvalid && req_tready;

   // result sink: changes its stall style now and then, one long hold-off on request
   initial begin : rsp_sink
      int unsigned style;
      int unsigned left;
      bit          held;
      rsp_tready = 1'b0;
      style = 0;
      left  = 0;
      held  = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_req && !held) begin
            held = 1'b1;
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
         end
         if (left == 0) begin
            style = $urandom_range(0, 3);
            left  = $urandom_range(16, 96);
         end
         left--;
         case (style)
            0:       rsp_tready <= 1'b1;
            1:       rsp_tready <= ($urandom_range(0, 1) != 0);
            2:       rsp_tready <= ($urandom_range(0, 3) == 0);
            default: rsp_tready <= ($urandom_range(0, 9) == 0);
         endcase
      end
   end

   // called at a falling edge, returns at a falling edge with the bus idle
   task automatic csr_write(input sfgh_pkg::csr_index_type idx, input logic [63:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 3'b000};
      csr_pwdata  <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(negedge clock);
      csr_writes++;
      if (idx == sfgh_pkg::REG_GATHER_MODE)
         strided_on = value[0];
   endtask

   task automatic push_byte(input logic [7:0] data, input logic last);
      int unsigned gap;
      if (burst_left == 0) begin
         gap = $urandom_range(0, gap_max);
         if (gap != 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         burst_left = $urandom_range(1, 32);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= data;
      req_tlast  <= last;
      do @(negedge clock); while (!req_taken);
      burst_left--;
      bytes_sent++;
      if (last) begin
         buffers_sent++;
         if (strided_on)
            strided_buffers++;
      end
   endtask

   task automatic send_buffer(input int unsigned length);
      for (int unsigned i = 0; i < length; i++)
         push_byte(8'($urandom_range(0, 255)), i == length - 1);
   endtask

   // block is idle once every result is out
   task automatic wait_idle();
      req_tvalid <= 1'b0;
      burst_left = 0;
      while (pending != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic configure(input logic [63:0] seed, input logic strided,
                            input logic [15:0] count, input logic [11:0] stride,
                            input logic [11:0] offset);
      wait_idle();
      csr_write(sfgh_pkg::REG_HASH_SEED, seed);
      csr_write(sfgh_pkg::REG_GATHER_MODE, {63'd0, strided});
      csr_write(sfgh_pkg::REG_VERTEX_COUNT, {48'd0, count});
      csr_write(sfgh_pkg::REG_VERTEX_STRIDE, {52'd0, stride});
      csr_write(sfgh_pkg::REG_POSITION_OFFSET, {52'd0, offset});
   endtask

   function automatic logic [63:0] pick_seed();
      case ($urandom_range(0, 7))
         0:       return '0;
         1:       return '1;
         2:       return BASIS_SEED;
         default: return {$urandom, $urandom};
      endcase
   endfunction

   initial begin : stimulus
      int unsigned kind;
      int unsigned count;
      int unsigned stride;
      int unsigned offset;
      int unsigned need;
      int unsigned length;
      int unsigned buffers;
      bit          pressure_done;

      reset       = 1'b1;
      req_tvalid  = 1'b0;
      req_tdata   = '0;
      req_tlast   = 1'b0;
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
      csr_paddr   = '0;
      csr_pwdata  = '0;
      hold_req    = 1'b0;
      strided_on  = 1'b0;
      burst_left  = 0;
      gap_max     = 3;
      bytes_sent = 0;
      buffers_sent = 0;
      strided_buffers = 0;
      csr_writes = 0;
      pressure_done = 1'b0;

      repeat (12) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // register reset values: contiguous mode, offset basis as seed
      push_byte(8'h00, 1'b0);
      push_byte(8'hff, 1'b1);
      push_byte(8'ha5, 1'b1);
      wait_idle();
      // strided with the reset vertex count of zero
      csr_write(sfgh_pkg::REG_GATHER_MODE, 64'd1);
      push_byte(8'h5a, 1'b1);
      // one vertex, buffer exactly as long as the layout
      configure('0, 1'b1, 16'd1, 12'd12, 12'd0);
      send_buffer(12);
      // zero stride: every byte starts a vertex
      configure('1, 1'b1, 16'd1, 12'd0, 12'd0);
      send_buffer(2);
      // position does not fit in the stride
      configure(BASIS_SEED, 1'b1, 16'd1, 12'd13, 12'd2);
      send_buffer(1);
      // largest count, stride and offset
      configure(BASIS_SEED, 1'b1, 16'hffff, 12'hfff, 12'hfff);
      send_buffer(3);

      while (bytes_sent < ITEM_TARGET) begin
         if (!pressure_done && bytes_sent > ITEM_TARGET / 2) begin
            // result sink stops for a long stretch while short buffers keep coming
            pressure_done = 1'b1;
            configure(pick_seed(), 1'b0, 16'($urandom), 12'($urandom), 12'($urandom));
            gap_max = 0;
            hold_req = 1'b1;
            repeat (24) send_buffer($urandom_range(1, 4));
         end
         gap_max = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         kind = $urandom_range(0, 9);
         buffers = $urandom_range(1, 3);
         if (kind < 3) begin
            configure(pick_seed(), 1'b0, 16'($urandom), 12'($urandom), 12'($urandom));
            repeat (buffers) send_buffer($urandom_range(1, 24));
         end else if (kind < 8) begin
            count  = $urandom_range(1, 4);
            stride = $urandom_range(12, 28);
            offset = $urandom_range(0, stride - 12);
            need   = (count - 1) * stride + offset + 12;
            configure(pick_seed(), 1'b1, 16'(count), 12'(stride), 12'(offset));
            repeat (buffers) begin
               // now and then one byte short of the layout
               length = ($urandom_range(0, 5) == 0) ? need - 1 : need + $urandom_range(0, 6);
               send_buffer(length);
            end
         end else begin
            count  = $urandom_range(1, 4);
            stride = $urandom_range(12, 20);
            offset = $urandom_range(0, stride - 12);
            case ($urandom_range(0, 4))
               0: count = 0;
               1: stride = $urandom_range(0, 11);
               2: offset = ($urandom_range(0, 1) != 0) ? 4095 : $urandom_range(stride - 11, 4095);
               3: begin
                  count  = 65535;
                  stride = 4095;
                  offset = $urandom_range(0, 4095);
               end
               default: begin
                  count  = $urandom_range(0, 65535);
                  stride = $urandom_range(0, 4095);
                  offset = $urandom_range(0, 4095);
               end
            endcase
            configure(pick_seed(), 1'b1, 16'(count), 12'(stride), 12'(offset));
            repeat (buffers) send_buffer($urandom_range(1, 40));
         end
      end

      wait_idle();
      repeat (8) @(negedge clock);
      $display("covered %0d bytes in %0d buffers (%0d strided), %0d csr writes",
               bytes_sent, buffers_sent, strided_buffers, csr_writes);
      $display("checked %0d results, %0d of them flagged a layout error",
               results_seen, layout_errors_seen);
      if (mismatches == 0 && pending == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule

@@ sim.f @@
+incdir+hdl
hdl/sfgh_pkg.sv
hdl/strided_fnv1a_gather_hash_core.sv
test/sfgh_hash_checker.sv
test/strided_fnv1a_gather_hash_core_tb.sv
